@@ rtl/dpp_pkg.sv @@
package dpp_pkg;

   localparam int DEPTH_BITS_DEF = 24;
   localparam int COORD_BITS_DEF = 12;

   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int OUT_DATA_W = 120;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NEAR_CLIP    = 4'd0,
      CSR_FAR_CLIP     = 4'd1,
      CSR_SCENE_EXTENT = 4'd2,
      CSR_FOCAL_X      = 4'd3,
      CSR_FOCAL_Y      = 4'd4,
      CSR_IMAGE_WIDTH  = 4'd5,
      CSR_IMAGE_HEIGHT = 4'd6,
      CSR_COLOR_ENABLE = 4'd7
   } csr_index_type;

   localparam logic [23:0] NEAR_CLIP_RST    = 24'd655;
   localparam logic [23:0] FAR_CLIP_RST     = 24'd3276800;
   localparam logic [31:0] SCENE_EXTENT_RST = 32'd65536;
   localparam logic [31:0] FOCAL_X_RST      = 32'd20971520;
   localparam logic [31:0] FOCAL_Y_RST      = 32'd20971520;
   localparam logic [12:0] IMAGE_WIDTH_RST  = 13'd640;
   localparam logic [12:0] IMAGE_HEIGHT_RST = 13'd480;

   typedef struct packed {
      logic sat;
      logic zero;
   } flags_type;

   typedef struct packed {
      logic [31:0] z;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      flags_type   flags;
      logic        ovf_x;
      logic        ovf_y;
      logic        neg_x;
   } xside_type;

endpackage

@@ rtl/dpp_div.sv @@
module dpp_div #(
   parameter int QB = 32,
   parameter int DW = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] in_hi,
   input  logic [QB-1:0] in_lo,
   input  logic [DW-1:0] in_div,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QB-1:0] out_quot,
   output logic [SW-1:0] out_side
);

   logic [QB-1:0] valid_ff;
   logic [DW-1:0] rem_ff  [QB];
   logic [QB-1:0] lo_ff   [QB];
   logic [DW-1:0] div_ff  [QB];
   logic [SW-1:0] side_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_step
      logic          valid_s;
      logic [DW-1:0] rem_s;
      logic [QB-1:0] lo_s;
      logic [DW-1:0] div_s;
      logic [SW-1:0] side_s;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign valid_s = in_valid;
         assign rem_s   = in_hi;
         assign lo_s    = in_lo;
         assign div_s   = in_div;
         assign side_s  = in_side;
      end else begin : g_next
         assign valid_s = valid_ff[k-1];
         assign rem_s   = rem_ff[k-1];
         assign lo_s    = lo_ff[k-1];
         assign div_s   = div_ff[k-1];
         assign side_s  = side_ff[k-1];
      end

      assign trial = {rem_s, lo_s[QB-1]};
      assign ge    = trial >= {1'b0, div_s};
      assign diff  = trial - {1'b0, div_s};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_s;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            lo_ff[k]   <= {lo_s[QB-2:0], ge};
            div_ff[k]  <= div_s;
            side_ff[k] <= side_s;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_quot  = lo_ff[QB-1];
   assign out_side  = side_ff[QB-1];

endmodule

@@ rtl/dpp_front.sv @@
module dpp_front #(
   parameter int DEPTH_BITS = dpp_pkg::DEPTH_BITS_DEF,
   parameter int COORD_BITS = dpp_pkg::COORD_BITS_DEF,
   localparam int DENW = 24 + DEPTH_BITS,
   localparam int PXW  = 2 * COORD_BITS + 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [DEPTH_BITS-1:0] in_raw,
   input  logic [PXW-1:0]        in_pix,
   input  logic [23:0]           near_clip,
   input  logic [23:0]           far_clip,
   input  logic [31:0]           scene_extent,
   input  logic [31:0]           focal_x,
   input  logic [31:0]           focal_y,
   output logic                  out_valid,
   output logic [DENW-1:0]       out_hi,
   output logic [47:0]           out_lo,
   output logic [DENW-1:0]       out_den,
   output logic [PXW-1:0]        out_pix,
   output dpp_pkg::flags_type    out_flags
);

   import dpp_pkg::*;

   localparam int NW  = 80 + DEPTH_BITS;
   localparam int HIW = NW - 48;

   logic [4:0]      valid_ff;
   logic [PXW-1:0]  pix_ff [5];
   logic [DEPTH_BITS-1:0] inv_raw;
   logic [DENW-1:0] p1_ff, p2_ff, nd1_ff, nd2_ff;
   logic [47:0]     nf_ff;
   logic [DENW-1:0] den2_ff, den3_ff, den4_ff, den5_ff;
   logic [63:0]     pa_ff, pb_ff;
   logic [79:0]     nfe_ff;
   logic            zero3_ff, zero4_ff;
   logic [NW-1:0]   num_ff;
   logic [HIW-1:0]  num_hi;
   logic            sat;
   flags_type       flags_ff;
   logic [DENW-1:0] hi_ff;
   logic [47:0]     lo_ff;

   assign inv_raw = ~in_raw;
   assign num_hi  = num_ff[NW-1:48];
   assign sat     = num_hi >= HIW'(den4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pix_ff[0] <= in_pix;
         for (int i = 1; i < 5; i++) begin
            pix_ff[i] <= pix_ff[i-1];
         end
         p1_ff  <= DENW'(far_clip) * DENW'(inv_raw);
         p2_ff  <= DENW'(near_clip) * DENW'(in_raw);
         nf_ff  <= 48'(near_clip) * 48'(far_clip);
         nd1_ff <= {near_clip, {DEPTH_BITS{1'b0}}} - DENW'(near_clip);

         den2_ff <= p1_ff + p2_ff;
         pa_ff   <= 64'(nf_ff) * 64'(scene_extent[15:0]);
         pb_ff   <= 64'(nf_ff) * 64'(scene_extent[31:16]);
         nd2_ff  <= nd1_ff;

         nfe_ff   <= 80'(pa_ff) + {pb_ff, 16'd0};
         zero3_ff <= (scene_extent == '0) || !(nd2_ff < den2_ff) ||
                     (focal_x == '0) || (focal_y == '0);
         den3_ff  <= den2_ff;

         num_ff   <= {nfe_ff, {DEPTH_BITS{1'b0}}} - NW'(nfe_ff);
         zero4_ff <= zero3_ff;
         den4_ff  <= den3_ff;

         hi_ff          <= sat ? '0 : num_hi[DENW-1:0];
         lo_ff          <= num_ff[47:0];
         den5_ff        <= den4_ff;
         flags_ff.sat   <= sat;
         flags_ff.zero  <= zero4_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_hi    = hi_ff;
   assign out_lo    = lo_ff;
   assign out_den   = den5_ff;
   assign out_pix   = pix_ff[4];
   assign out_flags = flags_ff;

endmodule

@@ rtl/dpp_offset.sv @@
module dpp_offset #(
   parameter int COORD_BITS = dpp_pkg::COORD_BITS_DEF,
   localparam int PXW = 2 * COORD_BITS + 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [31:0]        in_z,
   input  logic [PXW-1:0]     in_pix,
   input  dpp_pkg::flags_type in_flags,
   input  logic [12:0]        image_width,
   input  logic [12:0]        image_height,
   input  logic [31:0]        focal_x,
   input  logic [31:0]        focal_y,
   output logic               out_valid,
   output logic [31:0]        out_hi_x,
   output logic [31:0]        out_lo_x,
   output logic [31:0]        out_hi_y,
   output logic [31:0]        out_lo_y,
   output logic               out_neg_y,
   output dpp_pkg::xside_type out_side
);

   import dpp_pkg::*;

   localparam int OFFW = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
   localparam int PW   = OFFW + 32;
   localparam int HIW  = PW - 17;
   localparam int CW   = (HIW > 32) ? HIW : 32;

   logic [COORD_BITS-1:0] col, row;
   logic [OFFW:0]         twice_x, twice_y, size_x, size_y;
   logic                  neg_x, neg_y;
   logic [OFFW-1:0]       off_x, off_y;
   logic [HIW-1:0]        hi_x, hi_y;
   logic                  ovf_x, ovf_y;

   logic [1:0]      valid_ff;
   logic [PW-1:0]   prod_x_ff, prod_y_ff;
   logic            neg_x_ff, neg_y_ff, neg_y2_ff;
   logic [31:0]     z_ff;
   logic [23:0]     rgb_ff;
   flags_type       flags_ff;
   logic [31:0]     hi_x_ff, lo_x_ff, hi_y_ff, lo_y_ff;
   xside_type       side_ff;

   assign col     = in_pix[COORD_BITS-1:0];
   assign row     = in_pix[2*COORD_BITS-1:COORD_BITS];
   assign twice_x = (OFFW+1)'({col, 1'b0});
   assign twice_y = (OFFW+1)'({row, 1'b0});
   assign size_x  = (OFFW+1)'(image_width);
   assign size_y  = (OFFW+1)'(image_height);
   assign neg_x   = twice_x < size_x;
   assign neg_y   = twice_y < size_y;
   assign off_x   = neg_x ? OFFW'(size_x - twice_x) : OFFW'(twice_x - size_x);
   assign off_y   = neg_y ? OFFW'(size_y - twice_y) : OFFW'(twice_y - size_y);

   assign hi_x  = prod_x_ff[PW-1:17];
   assign hi_y  = prod_y_ff[PW-1:17];
   assign ovf_x = CW'(hi_x) >= CW'(focal_x);
   assign ovf_y = CW'(hi_y) >= CW'(focal_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= PW'(off_x) * PW'(in_z);
         prod_y_ff <= PW'(off_y) * PW'(in_z);
         neg_x_ff  <= neg_x;
         neg_y_ff  <= neg_y;
         z_ff      <= in_z;
         rgb_ff    <= in_pix[PXW-1:2*COORD_BITS];
         flags_ff  <= in_flags;

         hi_x_ff       <= ovf_x ? '0 : 32'(hi_x);
         lo_x_ff       <= {prod_x_ff[16:0], 15'd0};
         hi_y_ff       <= ovf_y ? '0 : 32'(hi_y);
         lo_y_ff       <= {prod_y_ff[16:0], 15'd0};
         neg_y2_ff     <= neg_y_ff;
         side_ff.z     <= z_ff;
         side_ff.red   <= rgb_ff[23:16];
         side_ff.green <= rgb_ff[15:8];
         side_ff.blue  <= rgb_ff[7:0];
         side_ff.flags <= flags_ff;
         side_ff.ovf_x <= ovf_x;
         side_ff.ovf_y <= ovf_y;
         side_ff.neg_x <= neg_x_ff;
      end
   end

   assign out_valid = valid_ff[1];
   assign out_hi_x  = hi_x_ff;
   assign out_lo_x  = lo_x_ff;
   assign out_hi_y  = hi_y_ff;
   assign out_lo_y  = lo_y_ff;
   assign out_neg_y = neg_y2_ff;
   assign out_side  = side_ff;

endmodule

@@ rtl/depth_pixel_to_point.sv @@
// An accepted req beat passes the front, depth divider, offset, x/y dividers and output register.
// Throughput: one pixel per cycle unless the output stalls; the depth divider (48 stages, one quotient
// bit each) and the x/y dividers (32 stages each) are fully pipelined.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset clears all valid bits and loads the register reset values.
module depth_pixel_to_point #(
   parameter int DEPTH_BITS = dpp_pkg::DEPTH_BITS_DEF,
   parameter int COORD_BITS = dpp_pkg::COORD_BITS_DEF,
   localparam int IN_W = ((DEPTH_BITS + 2 * COORD_BITS + 24 + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // raw_depth, pixel_column, pixel_row, blue_in, green_in, red_in
   input  logic [IN_W-1:0]                  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // point_x, point_y, point_z, red_out, green_out, blue_out
   output logic [dpp_pkg::OUT_DATA_W-1:0]   rsp_tdata,
   // point_valid
   output logic                             rsp_tuser,
   input  logic                             csr_wen,
   input  logic [dpp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dpp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import dpp_pkg::*;

   localparam int DENW = 24 + DEPTH_BITS;
   localparam int PXW  = 2 * COORD_BITS + 24;
   localparam int XSW  = $bits(xside_type);

   logic [23:0] near_ff, far_ff;
   logic [31:0] extent_ff, fx_ff, fy_ff;
   logic [12:0] width_ff, height_ff;
   logic        color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff   <= NEAR_CLIP_RST;
         far_ff    <= FAR_CLIP_RST;
         extent_ff <= SCENE_EXTENT_RST;
         fx_ff     <= FOCAL_X_RST;
         fy_ff     <= FOCAL_Y_RST;
         width_ff  <= IMAGE_WIDTH_RST;
         height_ff <= IMAGE_HEIGHT_RST;
         color_ff  <= 1'b1;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_NEAR_CLIP:    near_ff   <= csr_wdata[23:0];
            CSR_FAR_CLIP:     far_ff    <= csr_wdata[23:0];
            CSR_SCENE_EXTENT: extent_ff <= csr_wdata;
            CSR_FOCAL_X:      fx_ff     <= csr_wdata;
            CSR_FOCAL_Y:      fy_ff     <= csr_wdata;
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[12:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[12:0];
            CSR_COLOR_ENABLE: color_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   logic            fr_valid;
   logic [DENW-1:0] fr_hi, fr_den;
   logic [47:0]     fr_lo;
   logic [PXW-1:0]  fr_pix;
   flags_type       fr_flags;

   dpp_front #(.DEPTH_BITS(DEPTH_BITS), .COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .en,
      .in_valid     (req_tvalid),
      .in_raw       (req_tdata[DEPTH_BITS-1:0]),
      .in_pix       (req_tdata[DEPTH_BITS+PXW-1:DEPTH_BITS]),
      .near_clip    (near_ff),
      .far_clip     (far_ff),
      .scene_extent (extent_ff),
      .focal_x      (fx_ff),
      .focal_y      (fy_ff),
      .out_valid    (fr_valid),
      .out_hi       (fr_hi),
      .out_lo       (fr_lo),
      .out_den      (fr_den),
      .out_pix      (fr_pix),
      .out_flags    (fr_flags)
   );

   logic                 zd_valid;
   logic [47:0]          zd_quot;
   logic [PXW+1:0]       zd_side;
   flags_type            zd_flags;

   dpp_div #(.QB(48), .DW(DENW), .SW(PXW + 2)) u_zdiv (
      .clock, .reset, .en,
      .in_valid  (fr_valid),
      .in_hi     (fr_hi),
      .in_lo     (fr_lo),
      .in_div    (fr_den),
      .in_side   ({fr_pix, fr_flags}),
      .out_valid (zd_valid),
      .out_quot  (zd_quot),
      .out_side  (zd_side)
   );

   assign zd_flags = zd_side[1:0];

   logic        of_valid, of_neg_y;
   logic [31:0] of_hi_x, of_lo_x, of_hi_y, of_lo_y;
   xside_type   of_side;

   dpp_offset #(.COORD_BITS(COORD_BITS)) u_offset (
      .clock, .reset, .en,
      .in_valid     (zd_valid),
      .in_z         (zd_quot[47:16]),
      .in_pix       (zd_side[PXW+1:2]),
      .in_flags     (zd_flags),
      .image_width  (width_ff),
      .image_height (height_ff),
      .focal_x      (fx_ff),
      .focal_y      (fy_ff),
      .out_valid    (of_valid),
      .out_hi_x     (of_hi_x),
      .out_lo_x     (of_lo_x),
      .out_hi_y     (of_hi_y),
      .out_lo_y     (of_lo_y),
      .out_neg_y    (of_neg_y),
      .out_side     (of_side)
   );

   logic           xd_valid, yd_valid;
   logic [31:0]    qx, qy;
   logic [XSW-1:0] xd_side;
   logic           yd_neg;
   xside_type      fin;

   dpp_div #(.QB(32), .DW(32), .SW(XSW)) u_xdiv (
      .clock, .reset, .en,
      .in_valid  (of_valid),
      .in_hi     (of_hi_x),
      .in_lo     (of_lo_x),
      .in_div    (fx_ff),
      .in_side   (of_side),
      .out_valid (xd_valid),
      .out_quot  (qx),
      .out_side  (xd_side)
   );

   dpp_div #(.QB(32), .DW(32), .SW(1)) u_ydiv (
      .clock, .reset, .en,
      .in_valid  (of_valid),
      .in_hi     (of_hi_y),
      .in_lo     (of_lo_y),
      .in_div    (fy_ff),
      .in_side   (of_neg_y),
      .out_valid (yd_valid),
      .out_quot  (qy),
      .out_side  (yd_neg)
   );

   assign fin = xside_type'(xd_side);

   logic bad_x, bad_y, ok;

   assign bad_x = fin.neg_x ? (qx > 32'h8000_0000) : qx[31];
   assign bad_y = yd_neg ? (qy > 32'h8000_0000) : qy[31];
   assign ok    = !fin.flags.sat && !fin.flags.zero && !fin.ovf_x && !fin.ovf_y &&
                  !bad_x && !bad_y;

   logic [31:0] x_ff, y_ff, z_ff;
   logic [7:0]  r_ff, g_ff, b_ff;
   logic        pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= xd_valid && yd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= ok ? (fin.neg_x ? 32'(-qx) : qx) : '0;
         y_ff  <= ok ? (yd_neg ? 32'(-qy) : qy) : '0;
         z_ff  <= fin.flags.sat ? '1 : (ok ? fin.z : '0);
         r_ff  <= (ok && color_ff) ? fin.red : '0;
         g_ff  <= (ok && color_ff) ? fin.green : '0;
         b_ff  <= (ok && color_ff) ? fin.blue : '0;
         pv_ff <= ok;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {b_ff, g_ff, r_ff, z_ff, y_ff, x_ff};
   assign rsp_tuser  = pv_ff;

endmodule
